### rtl/jch_pkg.sv
// Shared types, constants and range tables for the joint colour histogram.
// No dependencies.
`timescale 1ns / 1ps

package jch_pkg;

    localparam int CH_W       = 24;
    localparam int D_W        = 23;
    localparam int PROD_W     = 26;
    localparam int CNT_W      = 21;
    localparam int MAX_BINS   = 4;
    localparam int BIN_W      = 2;
    localparam int NB_W       = 7;
    localparam int IDX_W      = 6;
    localparam int DEPTH      = 64;
    localparam int Q_W        = 17;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = CNT_W + FRAC_W + 1;
    localparam int SP_W       = 4;
    localparam int BINS_W     = 3;

    localparam logic [7:0]       MASK_THRESHOLD = 8'd250;
    localparam logic [CNT_W-1:0] MAX_PIXELS     = 21'd1048576;
    localparam logic [SP_W-1:0]  NUM_SPACES     = 4'd14;

    localparam logic [1:0] REG_SPACE = 2'd0;
    localparam logic [1:0] REG_C1    = 2'd1;
    localparam logic [1:0] REG_C2    = 2'd2;
    localparam logic [1:0] REG_C3    = 2'd3;

    localparam logic signed [CH_W-1:0] RANGE_LO [14][3] = '{
        '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, -24'sd823788, -24'sd823788},
        '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, -24'sd379290, -24'sd687923},
        '{24'sd0, 24'sd0, 24'sd0},
        '{24'sd0, -24'sd353075, -24'sd441958},
        '{-24'sd738714, -24'sd852828, 24'sd0},
        '{24'sd0, -24'sd522240, -24'sd1044480},
        '{24'sd0, 24'sd0, 24'sd0},
        '{-24'sd2048, -24'sd965140, -24'sd3288064},
        '{24'sd0, -24'sd340378, -24'sd549274},
        '{24'sd0, 24'sd0, 24'sd0}
    };

    localparam logic signed [CH_W-1:0] RANGE_HI [14][3] = '{
        '{24'sd1044480, 24'sd1044480, 24'sd1044480},
        '{24'sd4096, 24'sd4096, 24'sd4096},
        '{24'sd1044480, 24'sd823788, 24'sd823788},
        '{24'sd992748, 24'sd1044480, 24'sd1137213},
        '{24'sd4096, 24'sd4096, 24'sd1044480},
        '{24'sd1024819, 24'sd379290, 24'sd687923},
        '{24'sd1474560, 24'sd4096, 24'sd1044480},
        '{24'sd410010, 24'sd402637, 24'sd387072},
        '{24'sd738714, 24'sd852828, 24'sd1809203},
        '{24'sd1044480, 24'sd522240, 24'sd1044480},
        '{24'sd6554, 24'sd6554, 24'sd6554},
        '{24'sd1042432, 24'sd965140, 24'sd3288064},
        '{24'sd410010, 24'sd717210, 24'sd439910},
        '{24'sd2867, 24'sd2867, 24'sd2867}
    };

    typedef struct packed {
        logic load_pix;
        logic range_en;
        logic bin_en;
        logic upd_en;
        logic rd_issue;
        logic div_start;
        logic div_step;
        logic next_bin;
        logic clear;
    } jch_cmd_t;

    typedef struct packed {
        logic last_pixel;
        logic div_done;
        logic last_bin;
        logic empty;
    } jch_status_t;

    function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] n);
        logic [BINS_W-1:0] r;
        if (n == '0)
            r = BINS_W'(1);
        else if (n > BINS_W'(MAX_BINS))
            r = BINS_W'(MAX_BINS);
        else
            r = n;
        return r;
    endfunction

endpackage

### rtl/joint_color_histogram.sv
// Joint three-channel colour histogram with normalised Q1.16 readout.
// Top level; depends on jch_pkg, jch_ctrl, jch_datapath.
// Input channel: in_valid/in_ready, one pixel per transfer (three Q12 channels,
//   mask byte, last_pixel). Pixels with mask below 250 are ignored.
// Each pixel goes through four steps: capture, range check, bin select with count read,
//   count write. in_ready is high only while the block is idle.
// On the last pixel the block reads out one result per joint bin, in bin order,
//   on out_valid/out_ready. Each bin goes through memory read, divider load and
//   the bit-serial divider, then is held until the receiver takes it.
// The divider sets the readout rate; the count memory read-modify-write sets
//   the pixel rate.
// After the transfer of the final bin all counts and totals are cleared and
//   the block is idle again. A stalled receiver holds the result steady.
// Reset clears the counters (valid bits on the count memory) at once and loads
//   the default config: colour space 0, four bins per channel.
// Config writes (cfg_we, cfg_index, cfg_data) are taken in any cycle.
`timescale 1ns / 1ps

module joint_color_histogram
    import jch_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [SP_W-1:0]        cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [CH_W-1:0] chan_one,
    input  logic signed [CH_W-1:0] chan_two,
    input  logic signed [CH_W-1:0] chan_three,
    input  logic [7:0]             mask_level,
    input  logic                   last_pixel,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [IDX_W-1:0]       bin_num,
    output logic [Q_W-1:0]         share,
    output logic                   last_bin,
    output logic [CNT_W-1:0]       rejected_pixels,
    output logic                   no_pixels
);

    jch_cmd_t    cmd;
    jch_status_t st;

    jch_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    jch_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .chan_one        (chan_one),
        .chan_two        (chan_two),
        .chan_three      (chan_three),
        .mask_level      (mask_level),
        .last_pixel      (last_pixel),
        .bin_num         (bin_num),
        .share           (share),
        .last_bin        (last_bin),
        .rejected_pixels (rejected_pixels),
        .no_pixels       (no_pixels)
    );

endmodule

### rtl/jch_div.sv
// Bit-serial restoring divider: round(count * 2^16 / total), one quotient bit a cycle.
// Depends on jch_pkg.
`timescale 1ns / 1ps

module jch_div
    import jch_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             step,
    input  logic [CNT_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient,
    output logic             done
);

    logic [CNT_W-1:0] rem_reg;
    logic [Q_W-1:0]   low_reg;
    logic [Q_W-1:0]   q_reg;
    logic [4:0]       cnt_reg;
    logic [NUM_W-1:0] num;
    logic [CNT_W:0]   trial;
    logic             fits;

    assign num   = {1'b0, dividend, {FRAC_W{1'b0}}} + NUM_W'(divisor[CNT_W-1:1]);
    assign trial = {rem_reg, low_reg[Q_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:Q_W];
            low_reg <= num[Q_W-1:0];
            q_reg   <= '0;
        end
        else if (step)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
            low_reg <= {low_reg[Q_W-2:0], 1'b0};
            q_reg   <= {q_reg[Q_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = cnt_reg == 5'(Q_W - 1);

endmodule

### rtl/jch_datapath.sv
// Datapath: config registers, pixel binning stages, bin count memory, totals, readout.
// Depends on jch_pkg and jch_div.
`timescale 1ns / 1ps

module jch_datapath
    import jch_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  jch_cmd_t               cmd,
    output jch_status_t            st,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [SP_W-1:0]        cfg_data,
    input  logic signed [CH_W-1:0] chan_one,
    input  logic signed [CH_W-1:0] chan_two,
    input  logic signed [CH_W-1:0] chan_three,
    input  logic [7:0]             mask_level,
    input  logic                   last_pixel,
    output logic [IDX_W-1:0]       bin_num,
    output logic [Q_W-1:0]         share,
    output logic                   last_bin,
    output logic [CNT_W-1:0]       rejected_pixels,
    output logic                   no_pixels
);

    logic [SP_W-1:0]   color_space_reg;
    logic [BINS_W-1:0] c1_bins_reg, c2_bins_reg, c3_bins_reg;

    logic signed [CH_W-1:0] ch_reg [3];
    logic                   mask_ok_reg;
    logic                   last_reg;

    logic [D_W-1:0] d_reg    [3];
    logic [D_W-1:0] span_reg [3];
    logic           in_range_reg;
    logic           take_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             hit_reg;
    logic             miss_reg;

    logic [CNT_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [CNT_W-1:0] rd_reg;
    logic             rd_vld_reg;
    logic [CNT_W-1:0] count;

    logic [CNT_W-1:0] counted_reg;
    logic [CNT_W-1:0] rejected_reg;
    logic [IDX_W-1:0] b_reg;

    logic [BINS_W-1:0] n [3];
    logic [NB_W-1:0]   nb;
    logic [SP_W-1:0]   sp_sel;
    logic              sp_ok;
    logic              rng_ok [3];
    logic [D_W-1:0]    d_c    [3];
    logic [D_W-1:0]    span_c [3];
    logic [BIN_W-1:0]  bin_c  [3];
    logic [IDX_W-1:0]  idx_c;
    logic [IDX_W-1:0]  rd_addr;
    logic [Q_W-1:0]    quotient;

    function automatic logic [BIN_W-1:0] chan_bin(input logic [D_W-1:0] d,
                                                   input logic [D_W-1:0] span,
                                                   input logic [BINS_W-1:0] nn);
        logic [BIN_W-1:0]  r;
        logic [PROD_W-1:0] lhs;
        r   = BIN_W'(nn - BINS_W'(1));
        lhs = PROD_W'(d) * PROD_W'(nn);
        for (int k = MAX_BINS - 1; k >= 0; k--)
        begin
            if ((BINS_W'(k) < nn) && (lhs <= PROD_W'(span) * PROD_W'(k + 1)))
                r = BIN_W'(k);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c >= MAX_PIXELS) ? MAX_PIXELS : c + CNT_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_space_reg <= '0;
            c1_bins_reg     <= BINS_W'(4);
            c2_bins_reg     <= BINS_W'(4);
            c3_bins_reg     <= BINS_W'(4);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPACE: color_space_reg <= cfg_data;
                REG_C1:    c1_bins_reg     <= cfg_data[BINS_W-1:0];
                REG_C2:    c2_bins_reg     <= cfg_data[BINS_W-1:0];
                REG_C3:    c3_bins_reg     <= cfg_data[BINS_W-1:0];
                default:   ;
            endcase
        end
    end

    assign n[0]   = eff_bins(c1_bins_reg);
    assign n[1]   = eff_bins(c2_bins_reg);
    assign n[2]   = eff_bins(c3_bins_reg);
    assign nb     = NB_W'(n[0]) * NB_W'(n[1]) * NB_W'(n[2]);
    assign sp_ok  = color_space_reg < NUM_SPACES;
    assign sp_sel = sp_ok ? color_space_reg : '0;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rng_ok[c] = (ch_reg[c] >= RANGE_LO[sp_sel][c]) && (ch_reg[c] <= RANGE_HI[sp_sel][c]);
            d_c[c]    = D_W'(ch_reg[c] - RANGE_LO[sp_sel][c]);
            span_c[c] = D_W'(RANGE_HI[sp_sel][c] - RANGE_LO[sp_sel][c]);
            bin_c[c]  = chan_bin(d_reg[c], span_reg[c], n[c]);
        end
    end

    assign idx_c = IDX_W'(bin_c[0]) * IDX_W'(n[1]) * IDX_W'(n[2])
                 + IDX_W'(bin_c[1]) * IDX_W'(n[2]) + IDX_W'(bin_c[2]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            ch_reg[0]   <= chan_one;
            ch_reg[1]   <= chan_two;
            ch_reg[2]   <= chan_three;
            mask_ok_reg <= mask_level >= MASK_THRESHOLD;
            last_reg    <= last_pixel;
        end
        if (cmd.range_en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                d_reg[c]    <= d_c[c];
                span_reg[c] <= span_c[c];
            end
            in_range_reg <= sp_ok && rng_ok[0] && rng_ok[1] && rng_ok[2];
            take_reg     <= mask_ok_reg;
        end
        if (cmd.bin_en)
        begin
            idx_reg  <= idx_c;
            hit_reg  <= take_reg && in_range_reg;
            miss_reg <= take_reg && !in_range_reg;
        end
    end

    // count memory; an entry without its valid bit reads as zero
    assign rd_addr = cmd.bin_en ? idx_c : b_reg;
    assign count   = rd_vld_reg ? rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.upd_en && hit_reg)
            mem[idx_reg] <= sat_inc(count);
        if (cmd.bin_en || cmd.rd_issue)
            rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            counted_reg  <= '0;
            rejected_reg <= '0;
            b_reg        <= '0;
        end
        else
        begin
            if (cmd.bin_en || cmd.rd_issue)
                rd_vld_reg <= vld_reg[rd_addr];
            if (cmd.clear)
            begin
                vld_reg      <= '0;
                counted_reg  <= '0;
                rejected_reg <= '0;
                b_reg        <= '0;
            end
            else
            begin
                if (cmd.upd_en && hit_reg)
                begin
                    vld_reg[idx_reg] <= 1'b1;
                    counted_reg      <= sat_inc(counted_reg);
                end
                if (cmd.upd_en && miss_reg)
                    rejected_reg <= sat_inc(rejected_reg);
                if (cmd.next_bin)
                    b_reg <= b_reg + IDX_W'(1);
            end
        end
    end

    jch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (count),
        .divisor  (counted_reg),
        .quotient (quotient),
        .done     (st.div_done)
    );

    assign st.last_pixel = last_reg;
    assign st.last_bin   = NB_W'(b_reg) == nb - NB_W'(1);
    assign st.empty      = counted_reg == '0;

    assign bin_num         = b_reg;
    assign share           = st.empty ? '0 : quotient;
    assign last_bin        = st.last_bin;
    assign rejected_pixels = rejected_reg;
    assign no_pixels       = st.empty;

endmodule

### rtl/jch_ctrl.sv
// Controller FSM: sequences pixel update and the per-bin readout.
// Depends on jch_pkg.
`timescale 1ns / 1ps

module jch_ctrl
    import jch_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  jch_status_t st,
    output jch_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RANGE = 3'd1;
    localparam logic [2:0] ST_BIN   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = state_reg == ST_OUT;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                cmd.range_en = 1'b1;
                state_next   = ST_BIN;
            end
            ST_BIN:
            begin
                cmd.bin_en = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd_en = 1'b1;
                state_next = st.last_pixel ? ST_RD : ST_IDLE;
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (st.last_bin)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_bin = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> in_ready)
        else $error("clear not followed by idle");

    a_div_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && st.div_done) |=> out_valid)
        else $error("division done without output");

    a_step_one: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.bin_en, cmd.rd_issue, cmd.upd_en}) <= 1)
        else $error("memory port commands collide");

endmodule

### dv/tb_joint_color_histogram.sv
// Self-checking testbench for joint_color_histogram: directed and random pixels, bin
// counting and readout predicted in a scoreboard class. Depends on jch_pkg and the RTL.
`timescale 1ns / 1ps

module tb_joint_color_histogram;
    import jch_pkg::*;

    class hist_scoreboard;
        logic [3:0]       space;
        logic [2:0]       nbins [3];
        logic [CNT_W-1:0] counts [DEPTH];
        logic [CNT_W-1:0] counted;
        logic [CNT_W-1:0] rejected;
        logic [IDX_W-1:0] exp_idx [$];
        logic [Q_W-1:0]   exp_share [$];
        logic             exp_last [$];
        logic [CNT_W-1:0] exp_rej [$];
        logic             exp_empty [$];
        int               errors;

        function new();
            space = 0;
            nbins = '{3'd4, 3'd4, 3'd4};
            foreach (counts[i]) counts[i] = 0;
            counted = 0;
            rejected = 0;
            errors = 0;
        endfunction

        function int eff(logic [2:0] n);
            int r;
            r = (n == 0) ? 1 : (n > MAX_BINS) ? MAX_BINS : n;
            return r;
        endfunction

        function logic [CNT_W-1:0] sat(logic [CNT_W-1:0] c);
            logic [CNT_W-1:0] r;
            r = (c >= MAX_PIXELS) ? MAX_PIXELS : c + CNT_W'(1);
            return r;
        endfunction

        function int which_bin(logic signed [CH_W-1:0] v, int ch, int n);
            longint lo;
            longint hi;
            longint x;
            lo = RANGE_LO[space][ch];
            hi = RANGE_HI[space][ch];
            x = v;
            if (x < lo || x > hi) return -1;
            for (int k = 0; k < n; k++)
                if ((x - lo) * n <= longint'(k + 1) * (hi - lo)) return k;
            return n - 1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] d);
            if (idx == REG_SPACE) space = d;
            else nbins[idx - 1] = d[2:0];
        endfunction

        function void note_pixel(logic signed [CH_W-1:0] c1, logic signed [CH_W-1:0] c2,
                                 logic signed [CH_W-1:0] c3, logic [7:0] m, logic lst);
            int n1;
            int n2;
            int n3;
            int i1;
            int i2;
            int i3;
            int nb;
            longint sh;
            n1 = eff(nbins[0]);
            n2 = eff(nbins[1]);
            n3 = eff(nbins[2]);
            nb = n1 * n2 * n3;
            if (m >= MASK_THRESHOLD) begin
                i1 = -1; i2 = -1; i3 = -1;
                if (space < NUM_SPACES) begin
                    i1 = which_bin(c1, 0, n1);
                    i2 = which_bin(c2, 1, n2);
                    i3 = which_bin(c3, 2, n3);
                end
                if (i1 < 0 || i2 < 0 || i3 < 0)
                    rejected = sat(rejected);
                else begin
                    counts[i1 * n2 * n3 + i2 * n3 + i3] =
                        sat(counts[i1 * n2 * n3 + i2 * n3 + i3]);
                    counted = sat(counted);
                end
            end
            if (!lst) return;
            for (int b = 0; b < nb; b++) begin
                sh = 0;
                if (counted != 0) begin
                    sh = (longint'(counts[b]) * 65536 + counted / 2) / counted;
                    if (sh > 65536) sh = 65536;
                end
                exp_idx = {exp_idx, IDX_W'(b)};
                exp_share = {exp_share, Q_W'(sh)};
                exp_last = {exp_last, (b == nb - 1)};
                exp_rej = {exp_rej, rejected};
                exp_empty = {exp_empty, (counted == 0)};
            end
            foreach (counts[i]) counts[i] = 0;
            counted = 0;
            rejected = 0;
        endfunction

        function void check_bin(logic [IDX_W-1:0] idx, logic [Q_W-1:0] sh, logic lb,
                                logic [CNT_W-1:0] rj, logic np);
            if (exp_idx.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result bin %0d", idx);
                return;
            end
            if (idx !== exp_idx[0] || sh !== exp_share[0] || lb !== exp_last[0]
                || rj !== exp_rej[0] || np !== exp_empty[0]) begin
                errors++;
                if (errors <= 10)
                    $display("bin exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                             exp_idx[0], exp_share[0], exp_last[0], exp_rej[0],
                             exp_empty[0], idx, sh, lb, rj, np);
            end
            void'(exp_idx.pop_front());
            void'(exp_share.pop_front());
            void'(exp_last.pop_front());
            void'(exp_rej.pop_front());
            void'(exp_empty.pop_front());
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [SP_W-1:0]        cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic signed [CH_W-1:0] chan_one;
    logic signed [CH_W-1:0] chan_two;
    logic signed [CH_W-1:0] chan_three;
    logic [7:0]             mask_level;
    logic                   last_pixel;
    logic                   out_valid;
    logic                   out_ready;
    logic [IDX_W-1:0]       bin_num;
    logic [Q_W-1:0]         share;
    logic                   last_bin;
    logic [CNT_W-1:0]       rejected_pixels;
    logic                   no_pixels;

    hist_scoreboard sb;
    int             cycles;
    bit             hold_off;

    joint_color_histogram u_dut (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    function int gap_len();
        int r;
        r = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
        return r;
    endfunction

    task automatic write_cfg(logic [1:0] idx, logic [3:0] d);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.write_reg(idx, d);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // valid stays up between back-to-back pixels; drain() drops it
    task automatic send_pixel(logic signed [CH_W-1:0] c1, logic signed [CH_W-1:0] c2,
                              logic signed [CH_W-1:0] c3, logic [7:0] m, logic lst,
                              bit nogap);
        int g;
        g = nogap ? 0 : gap_len();
        @(negedge clk);
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1;
        chan_one <= c1;
        chan_two <= c2;
        chan_three <= c3;
        mask_level <= m;
        last_pixel <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_pixel(c1, c2, c3, m, lst);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.exp_idx.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // Value near a range boundary or a quarter point, anywhere in the range, or any 24-bit value
    function logic signed [CH_W-1:0] chan_val(int ch);
        longint lo;
        longint hi;
        longint v;
        int sel;
        lo = RANGE_LO[sb.space < NUM_SPACES ? sb.space : 0][ch];
        hi = RANGE_HI[sb.space < NUM_SPACES ? sb.space : 0][ch];
        sel = $urandom_range(0, 9);
        if (sel == 0) v = $signed(24'($urandom()));
        else if (sel == 1) v = lo + $urandom_range(0, 2) - 1;
        else if (sel == 2) v = hi + $urandom_range(0, 2) - 1;
        else if (sel == 3) v = lo + (hi - lo) * $urandom_range(1, 3) / 4
                               + $urandom_range(0, 2) - 1;
        else v = lo + longint'($urandom_range(0, 32'(hi - lo)));
        return CH_W'(v);
    endfunction

    task automatic random_image(int npix);
        for (int i = 0; i < npix; i++)
            send_pixel(chan_val(0), chan_val(1), chan_val(2),
                       ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(250, 255)),
                       i == npix - 1, 0);
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_bin(bin_num, share, last_bin, rejected_pixels, no_pixels);
    end

    initial begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off) out_ready <= 0;
            else begin
                g = gap_len();
                if (g > 0) begin
                    out_ready <= 0;
                    repeat (g) @(negedge clk);
                end
                out_ready <= !hold_off;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        hold_off = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_SPACE;
        cfg_data = 0;
        in_valid = 0;
        chan_one = 0;
        chan_two = 0;
        chan_three = 0;
        mask_level = 0;
        last_pixel = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty image, extremes, boundaries, masks, out-of-range config
        send_pixel(0, 0, 0, 8'd249, 1, 0);
        drain();
        send_pixel(24'sh7FFFFF, 24'sh800000, 0, 8'd255, 0, 0);
        send_pixel(0, 0, 0, 8'd250, 0, 0);
        send_pixel(24'sd1044480, 24'sd1044480, 24'sd1044480, 8'd255, 0, 0);
        send_pixel(24'sd261120, 24'sd522240, 24'sd783360, 8'd252, 0, 0);
        send_pixel(24'sd261121, 24'sd522241, 24'sd783361, 8'd0, 0, 0);
        send_pixel(24'sd261121, 24'sd522241, 24'sd783361, 8'd251, 1, 0);
        drain();
        write_cfg(REG_SPACE, 4'd15);
        write_cfg(REG_C1, 4'd0);
        write_cfg(REG_C2, 4'd7);
        write_cfg(REG_C3, 4'd1);
        send_pixel(0, 0, 0, 8'd255, 0, 0);
        send_pixel(24'sh555555, 24'shAAAAAA, 24'sh7FFFFF, 8'd255, 1, 0);
        drain();
        write_cfg(REG_SPACE, 4'd11);
        write_cfg(REG_C2, 4'd3);
        send_pixel(-24'sd2048, -24'sd965140, -24'sd3288064, 8'd255, 0, 0);
        send_pixel(24'sd1042432, 24'sd965140, 24'sd3288064, 8'd255, 1, 0);
        drain();

        // receiver held off while images keep coming
        write_cfg(REG_SPACE, 4'd0);
        write_cfg(REG_C1, 4'd4);
        write_cfg(REG_C2, 4'd4);
        write_cfg(REG_C3, 4'd4);
        hold_off = 1;
        fork
            begin
                repeat (2500) @(posedge clk);
                hold_off = 0;
            end
            begin
                random_image(4);
                random_image(3);
            end
        join
        drain();

        for (int im = 0; im < 60; im++) begin
            for (int r = 0; r < 4; r++)
                write_cfg(r[1:0], (r == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 7)));
            random_image($urandom_range(1, 14));
            drain();
        end
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.exp_idx.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
